// File: rtl/core/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants of the integer list sorter.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [31:0] value;
        logic               last_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_result;
        logic               overflow;
    } t_out_item;

    // queue head as seen by the sort engine
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_queue_head;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_back_state;

endpackage

// File: rtl/core/ils_intake_queue.sv
// ----------------------------------------------------------------------------
// ils_intake_queue
// Front end: takes transactions off the command port and holds them in a
// short queue until the sort engine pops them.
// ----------------------------------------------------------------------------
module ils_intake_queue
    import ils_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in_item    i_item,
    output logic        o_busy,
    output t_queue_head o_head,
    input  logic        i_pop
);

    t_in_item            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]   n_count;
    logic                push;
    logic                pop;

    assign o_busy      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push        = i_start && !o_busy;
    assign pop         = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: rtl/core/ils_sort_engine.sv
// ----------------------------------------------------------------------------
// ils_sort_engine
// Back end: inserts queued values into a row of sorted cells, one per cycle
// while loading, then shifts the row out on the marked transaction.
// ----------------------------------------------------------------------------
module ils_sort_engine
    import ils_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    output logic        o_result_valid,
    output t_out_item   o_result
);

    t_back_state               r_state;
    t_back_state               n_state;
    logic [31:0]               r_cell  [MAX_ELEMENTS];
    logic [31:0]               n_cell  [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]   r_valid;
    logic [MAX_ELEMENTS-1:0]   n_valid;
    logic [MAX_ELEMENTS-1:0]   gt;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_drop;
    logic                      n_drop;
    logic                      r_out_valid;
    t_out_item                 r_out;
    logic                      take;
    logic                      full;
    logic                      do_shift;

    assign full = (r_count == CNT_W'(MAX_ELEMENTS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_head.valid && i_head.item.last_value) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_count == CNT_W'(1)) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop    = 1'b0;
        do_shift = 1'b0;
        case (r_state)
            ST_LOAD: o_pop    = 1'b1;
            ST_EMIT: do_shift = 1'b1;
            default: begin
                o_pop    = 1'b0;
                do_shift = 1'b0;
            end
        endcase
    end

    assign take = o_pop && i_head.valid;

    // empty cells count as larger than anything, equal values keep arrival order
    always_comb begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            gt[i] = !r_valid[i] || ($signed(r_cell[i]) > $signed(i_head.item.value));
        end
    end

    always_comb begin
        n_cell  = r_cell;
        n_valid = r_valid;
        n_count = r_count;
        n_drop  = r_drop;
        if (do_shift) begin
            for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
                n_cell[i]  = r_cell[i+1];
                n_valid[i] = r_valid[i+1];
            end
            n_valid[MAX_ELEMENTS-1] = 1'b0;
            n_count = r_count - 1'b1;
            if (r_count == CNT_W'(1)) begin
                n_drop = 1'b0;
            end
        end else if (take) begin
            if (full) begin
                n_drop = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
                if (gt[0]) begin
                    n_cell[0]  = i_head.item.value;
                    n_valid[0] = 1'b1;
                end
                for (int i = 1; i < MAX_ELEMENTS; i++) begin
                    if (gt[i]) begin
                        n_cell[i]  = gt[i-1] ? r_cell[i-1] : i_head.item.value;
                        n_valid[i] = gt[i-1] ? r_valid[i-1] : 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_valid     <= '0;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_out_valid <= do_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (do_shift) begin
            r_out.sorted_value <= r_cell[0];
            r_out.last_result  <= (r_count == CNT_W'(1));
            r_out.overflow     <= r_drop;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("valid cells disagree with element count");

    a_last_empties_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_result) |-> (r_count == '0 && r_state == ST_LOAD))
        else $error("final result left cells behind");

    a_no_pop_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !o_pop)
        else $error("queue popped during emit");

    a_emit_from_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_count != '0))
        else $error("emit with empty row");

endmodule

// File: rtl/core/integer_list_sorter.sv
// ----------------------------------------------------------------------------
// integer_list_sorter
// Sorts a list of signed 32-bit values into ascending order, stable on ties.
// ----------------------------------------------------------------------------
// Loading takes one value per cycle, while no run is being shifted out, through a
// 4-entry queue into 64 insert cells. The first result passes the queue, the row
// and the output register, behind any transactions queued ahead of the marked one
// and results of a run still out; then one result per cycle; results cannot stall.
// During a run the row takes no values, so busy rises once the queue is full.
// Synchronous active-low reset empties the queue and the row.
// ----------------------------------------------------------------------------
module integer_list_sorter
    import ils_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_busy,
    output logic      o_result_valid,
    output t_out_item o_result
);

    t_queue_head head;
    logic        pop;

    ils_intake_queue u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (i_item),
        .o_busy  (o_busy),
        .o_head  (head),
        .i_pop   (pop)
    );

    ils_sort_engine u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
